### hw/rtl/rv32ex_pkg.sv
// Shared types, operation codes and constants for the RV32 execute stage.
`timescale 1ns / 1ps
`default_nettype none

package rv32ex_pkg;

    localparam int unsigned XLEN = 32;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned SHAMT_W = 5;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;
    localparam logic [XLEN-1:0] PC_RESET_DEFAULT = 32'd0;

    // ALU operation codes.
    localparam logic [3:0] ALU_ADD  = 4'd0;
    localparam logic [3:0] ALU_SUB  = 4'd1;
    localparam logic [3:0] ALU_SLT  = 4'd2;
    localparam logic [3:0] ALU_LTU  = 4'd3;
    localparam logic [3:0] ALU_OR   = 4'd4;
    localparam logic [3:0] ALU_XOR  = 4'd5;
    localparam logic [3:0] ALU_AND  = 4'd6;
    localparam logic [3:0] ALU_SLL  = 4'd7;
    localparam logic [3:0] ALU_SRL  = 4'd8;
    localparam logic [3:0] ALU_SRA  = 4'd9;

    // Branch condition codes.
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd2;
    localparam logic [2:0] BR_GE  = 3'd3;
    localparam logic [2:0] BR_LTU = 3'd4;
    localparam logic [2:0] BR_GEU = 3'd5;

    typedef struct packed {
        logic [XLEN-1:0]      rs1_val;
        logic [XLEN-1:0]      rs2_val;
        logic [XLEN-1:0]      imm;
        logic                 use_imm;
        logic [3:0]           alu_op;
        logic                 is_branch;
        logic [2:0]           branch_kind;
        logic                 jump_taken;
        logic                 target_from_rs1;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [XLEN-1:0]      link_address;
    } exec_in_t;

    typedef struct packed {
        logic [XLEN-1:0]      alu_result;
        logic [XLEN-1:0]      store_data;
        logic [REG_IDX_W-1:0] dest_reg_out;
        logic [XLEN-1:0]      link_address_out;
        logic                 redirect;
        logic [XLEN-1:0]      next_pc;
    } exec_out_t;

    // Control flow outcome handed from the next-PC unit to the top level.
    typedef struct packed {
        logic            redirect;
        logic [XLEN-1:0] next_pc;
    } pc_update_t;

endpackage

`default_nettype wire

### hw/rtl/rv32ex_alu.sv
// Integer ALU of the execute stage: arithmetic, compares, logic and shifts.
`timescale 1ns / 1ps
`default_nettype none

module rv32ex_alu (
    input  wire logic [rv32ex_pkg::XLEN-1:0] op_a,
    input  wire logic [rv32ex_pkg::XLEN-1:0] op_b,
    input  wire logic [3:0]                  alu_op,
    output logic      [rv32ex_pkg::XLEN-1:0] result
);

    logic [rv32ex_pkg::SHAMT_W-1:0] shamt;

    assign shamt = op_b[rv32ex_pkg::SHAMT_W-1:0];

    always_comb
    begin
        case (alu_op)
            rv32ex_pkg::ALU_ADD:  result = op_a + op_b;
            rv32ex_pkg::ALU_SUB:  result = op_a - op_b;
            rv32ex_pkg::ALU_SLT:  result = {{(rv32ex_pkg::XLEN-1){1'b0}},
                                            ($signed(op_a) < $signed(op_b))};
            rv32ex_pkg::ALU_LTU:  result = {{(rv32ex_pkg::XLEN-1){1'b0}}, (op_a < op_b)};
            rv32ex_pkg::ALU_OR:   result = op_a | op_b;
            rv32ex_pkg::ALU_XOR:  result = op_a ^ op_b;
            rv32ex_pkg::ALU_AND:  result = op_a & op_b;
            rv32ex_pkg::ALU_SLL:  result = op_a << shamt;
            rv32ex_pkg::ALU_SRL:  result = op_a >> shamt;
            rv32ex_pkg::ALU_SRA:  result = $unsigned($signed(op_a) >>> shamt);
            default:              result = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/rv32ex_next_pc.sv
// Branch resolution and next program counter selection.
`timescale 1ns / 1ps
`default_nettype none

module rv32ex_next_pc (
    input  wire logic [rv32ex_pkg::XLEN-1:0] pc,
    input  wire logic [rv32ex_pkg::XLEN-1:0] op_a,
    input  wire logic [rv32ex_pkg::XLEN-1:0] op_b,
    input  wire logic [rv32ex_pkg::XLEN-1:0] imm,
    input  wire logic                        is_branch,
    input  wire logic [2:0]                  branch_kind,
    input  wire logic                        jump_taken,
    input  wire logic                        target_from_rs1,
    output rv32ex_pkg::pc_update_t           update
);

    logic                        cond_met;
    logic                        take;
    logic [rv32ex_pkg::XLEN-1:0] target_base;

    always_comb
    begin
        case (branch_kind)
            rv32ex_pkg::BR_EQ:  cond_met = (op_a == op_b);
            rv32ex_pkg::BR_NE:  cond_met = (op_a != op_b);
            rv32ex_pkg::BR_LT:  cond_met = ($signed(op_a) < $signed(op_b));
            rv32ex_pkg::BR_GE:  cond_met = !($signed(op_a) < $signed(op_b));
            rv32ex_pkg::BR_LTU: cond_met = (op_a < op_b);
            rv32ex_pkg::BR_GEU: cond_met = !(op_a < op_b);
            default:            cond_met = 1'b0;
        endcase
    end

    // A conditional branch ignores the jump flag; its condition decides.
    assign take = is_branch ? cond_met : jump_taken;
    assign target_base = target_from_rs1 ? op_a : pc;

    assign update.redirect = take;
    assign update.next_pc  = take ? (target_base + imm) : (pc + rv32ex_pkg::PC_STEP);

endmodule

`default_nettype wire

### hw/rtl/rv32_execute_stage_unit.sv
// Top level of the RV32 execute stage: input register, execute logic, result register.
// An input is held in the stage-one register and its result in the stage-two register;
// an output stall holds it in stage one. Throughput: one item per cycle while out_ready
// holds; the program counter feedback is a single add and select. A stalled result still
// lets one more input transfer into stage one before the input stops.
// Reset: asynchronous, active low; clears both stage valids and loads the program counter
// with PC_RESET_DEFAULT, the zero value that reset also writes to pc_reset_value_reg.
`timescale 1ns / 1ps
`default_nettype none

module rv32_execute_stage_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire rv32ex_pkg::exec_in_t        in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rv32ex_pkg::exec_out_t            out_data,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rv32ex_pkg::XLEN-1:0] cfg_data
);

    // Stage one holds the decoded instruction, stage two holds the finished result.
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    rv32ex_pkg::exec_in_t        s1_data_reg;
    logic                        s2_valid_reg;
    logic                        s2_valid_next;
    rv32ex_pkg::exec_out_t       s2_data_reg;
    rv32ex_pkg::exec_out_t       s2_data_next;

    // Architectural program counter, advanced once per instruction leaving stage one.
    logic [rv32ex_pkg::XLEN-1:0] pc_reg;
    logic [rv32ex_pkg::XLEN-1:0] pc_next;

    // The configured reset value. Because reset also returns this register to its
    // default, the program counter always comes out of reset at that default.
    logic [rv32ex_pkg::XLEN-1:0] pc_reset_value_reg;
    logic [rv32ex_pkg::XLEN-1:0] pc_reset_value_next;

    logic                        in_xfer;
    logic                        advance;
    logic [rv32ex_pkg::XLEN-1:0] op_b;
    logic [rv32ex_pkg::XLEN-1:0] alu_result;
    rv32ex_pkg::pc_update_t      pc_update;

    // Stage one moves into stage two whenever stage two is empty or being drained.
    assign advance   = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // The configuration register takes a transfer in every cycle.
    assign cfg_ready = 1'b1;
    assign pc_reset_value_next = (cfg_valid && cfg_ready) ? cfg_data : pc_reset_value_reg;

    assign op_b = s1_data_reg.use_imm ? s1_data_reg.imm : s1_data_reg.rs2_val;

    rv32ex_alu u_alu (
        .op_a   (s1_data_reg.rs1_val),
        .op_b   (op_b),
        .alu_op (s1_data_reg.alu_op),
        .result (alu_result)
    );

    rv32ex_next_pc u_next_pc (
        .pc              (pc_reg),
        .op_a            (s1_data_reg.rs1_val),
        .op_b            (op_b),
        .imm             (s1_data_reg.imm),
        .is_branch       (s1_data_reg.is_branch),
        .branch_kind     (s1_data_reg.branch_kind),
        .jump_taken      (s1_data_reg.jump_taken),
        .target_from_rs1 (s1_data_reg.target_from_rs1),
        .update          (pc_update)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        s2_data_next.alu_result       = alu_result;
        s2_data_next.store_data       = s1_data_reg.rs2_val;
        s2_data_next.dest_reg_out     = s1_data_reg.dest_reg;
        s2_data_next.link_address_out = s1_data_reg.link_address;
        s2_data_next.redirect         = pc_update.redirect;
        s2_data_next.next_pc          = pc_update.next_pc;
    end

    assign pc_next = advance ? pc_update.next_pc : pc_reg;

    // Control state and the program counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            pc_reg             <= rv32ex_pkg::PC_RESET_DEFAULT;
            pc_reset_value_reg <= rv32ex_pkg::PC_RESET_DEFAULT;
        end
        else
        begin
            s1_valid_reg       <= s1_valid_next;
            s2_valid_reg       <= s2_valid_next;
            pc_reg             <= pc_next;
            pc_reset_value_reg <= pc_reset_value_next;
        end
    end

    // Payload registers, loaded only on a transfer into each stage.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

`ifndef SYNTHESIS
    // The program counter only moves when an instruction completes execution.
    a_pc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pc_reg))
        else $error("program counter changed without an instruction advancing");

    // The reported next_pc always matches the architectural program counter.
    a_next_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (s2_data_reg.next_pc == pc_reg))
        else $error("result next_pc differs from program counter");

    // Without a redirect the program counter steps by one instruction.
    a_sequential_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !pc_update.redirect) |=>
            (pc_reg == ($past(pc_reg) + rv32ex_pkg::PC_STEP)))
        else $error("program counter did not advance by four");

    // A finished result is never overwritten while it waits.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |-> !advance)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the RV32 execute stage: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    import rv32ex_pkg::*;

    // Opcode ranges that the block decodes as no-ops. They have no names in the
    // package, so they get names here.
    localparam logic [3:0] ALU_UNUSED_LO = 4'd10;
    localparam logic [3:0] ALU_UNUSED_HI = 4'd15;
    localparam logic [2:0] BR_NEVER_LO   = 3'd6;
    localparam logic [2:0] BR_NEVER_HI   = 3'd7;

    // Settling time after the last result, longer than an item takes through both stage registers.
    localparam int DRAIN_CYCLES = 20;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    exec_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    exec_out_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [XLEN-1:0] cfg_data;

    // One row of the directed table. When has_result is set, the result is
    // typed in by hand and pushed instead of the predicted one.
    typedef struct {
        exec_in_t  instr;
        bit        has_result;
        exec_out_t result;
    } directed_row_t;

    // Architectural state as the scoreboard sees it.
    logic [XLEN-1:0] arch_pc;

    exec_out_t pending_results[$];
    directed_row_t directed_tbl[$];

    int unsigned mismatch_count = 0;
    int unsigned burst_left = 1;

    rv32_execute_stage_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs or results go missing.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Prints one line per wrong or unexpected field and counts it.
    task automatic report_mismatch(input string what, input logic [XLEN-1:0] got,
                                   input logic [XLEN-1:0] want);
        $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Predicts one instruction: the ALU result, the branch or jump decision
    // and the new program counter. Updates arch_pc as a side effect.
    function automatic exec_out_t execute_instr(input exec_in_t instr);
        exec_out_t       res;
        logic [XLEN-1:0] op_a;
        logic [XLEN-1:0] op_b;
        logic [SHAMT_W-1:0] shamt;
        logic            taken;
        op_a  = instr.rs1_val;
        op_b  = instr.use_imm ? instr.imm : instr.rs2_val;
        shamt = op_b[SHAMT_W-1:0];
        case (instr.alu_op)
            ALU_ADD:  res.alu_result = op_a + op_b;
            ALU_SUB:  res.alu_result = op_a - op_b;
            ALU_SLT:  res.alu_result = {31'b0, $signed(op_a) < $signed(op_b)};
            ALU_LTU:  res.alu_result = {31'b0, op_a < op_b};
            ALU_OR:   res.alu_result = op_a | op_b;
            ALU_XOR:  res.alu_result = op_a ^ op_b;
            ALU_AND:  res.alu_result = op_a & op_b;
            ALU_SLL:  res.alu_result = op_a << shamt;
            ALU_SRL:  res.alu_result = op_a >> shamt;
            ALU_SRA:  res.alu_result = $signed(op_a) >>> shamt;
            default:  res.alu_result = '0;
        endcase
        // A conditional branch always compares A against the selected B,
        // whatever the ALU is doing, and it overrides jump_taken.
        if (instr.is_branch)
        begin
            case (instr.branch_kind)
                BR_EQ:   taken = (op_a == op_b);
                BR_NE:   taken = (op_a != op_b);
                BR_LT:   taken = ($signed(op_a) < $signed(op_b));
                BR_GE:   taken = !($signed(op_a) < $signed(op_b));
                BR_LTU:  taken = (op_a < op_b);
                BR_GEU:  taken = !(op_a < op_b);
                default: taken = 1'b0;
            endcase
        end
        else
        begin
            taken = instr.jump_taken;
        end
        if (taken)
            arch_pc = (instr.target_from_rs1 ? instr.rs1_val : arch_pc) + instr.imm;
        else
            arch_pc = arch_pc + PC_STEP;
        res.store_data       = instr.rs2_val;
        res.dest_reg_out     = instr.dest_reg;
        res.link_address_out = instr.link_address;
        res.redirect         = taken;
        res.next_pc          = arch_pc;
        return res;
    endfunction

    function automatic exec_in_t instr(input logic [XLEN-1:0] rs1, input logic [XLEN-1:0] rs2,
                                       input logic [XLEN-1:0] imm, input logic use_imm,
                                       input logic [3:0] op, input logic is_branch,
                                       input logic [2:0] kind, input logic jump,
                                       input logic from_rs1, input logic [4:0] rd,
                                       input logic [XLEN-1:0] link);
        return '{rs1, rs2, imm, use_imm, op, is_branch, kind, jump, from_rs1, rd, link};
    endfunction

    function automatic exec_out_t outcome(input logic [XLEN-1:0] alu, input logic [XLEN-1:0] sd,
                                          input logic [4:0] rd, input logic [XLEN-1:0] link,
                                          input logic redirect, input logic [XLEN-1:0] npc);
        return '{alu, sd, rd, link, redirect, npc};
    endfunction

    // Operand values lean toward the corners: zero, all ones, the sign
    // boundary and small shift-sized numbers.
    function automatic logic [XLEN-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return XLEN'($urandom_range(0, 64));
            default: return $urandom;
        endcase
    endfunction

    function automatic exec_in_t random_instr();
        exec_in_t it;
        it.rs1_val         = pick_operand();
        it.rs2_val         = pick_operand();
        it.imm             = pick_operand();
        it.use_imm         = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
            it.alu_op = 4'($urandom_range(ALU_UNUSED_LO, ALU_UNUSED_HI));
        else
            it.alu_op = 4'($urandom_range(ALU_ADD, ALU_SRA));
        it.is_branch       = ($urandom_range(0, 9) < 4);
        if ($urandom_range(0, 7) == 0)
            it.branch_kind = 3'($urandom_range(BR_NEVER_LO, BR_NEVER_HI));
        else
            it.branch_kind = 3'($urandom_range(BR_EQ, BR_GEU));
        it.jump_taken      = 1'($urandom_range(0, 1));
        it.target_from_rs1 = 1'($urandom_range(0, 1));
        it.dest_reg        = 5'($urandom_range(0, 31));
        it.link_address    = $urandom;
        // Equal operands make the eq/ne/ge conditions hit both ways.
        if ($urandom_range(0, 4) == 0)
        begin
            if (it.use_imm)
                it.imm = it.rs1_val;
            else
                it.rs2_val = it.rs1_val;
        end
        return it;
    endfunction

    // Presents one instruction, holds it until the transfer, then records the
    // expected result. At the end of a burst the sender may go idle for a while.
    task automatic send_instr(input exec_in_t item, input bit has_result,
                              input exec_out_t typed_result);
        exec_out_t predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = execute_instr(item);
        pending_results.push_back(has_result ? typed_result : predicted);
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Drops valid and waits for every outstanding result to come back.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes pc_reset_value. The block never reads it, so the program counter
    // keeps running.
    task automatic write_pc_reset(input logic [XLEN-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver back-pressure: a rotating 8-bit ready pattern, re-chosen every
    // so often. A quarter of the time it is all ones, giving stall-free runs.
    initial
    begin
        logic [7:0] ready_pattern;
        int         pattern_left;
        ready_pattern = 8'hFF;
        pattern_left  = 0;
        out_ready     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pattern_left == 0)
            begin
                pattern_left = $urandom_range(16, 96);
                if ($urandom_range(0, 3) == 0)
                    ready_pattern = 8'hFF;
                else
                    ready_pattern = 8'($urandom_range(1, 255));
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            pattern_left--;
        end
    end

    // Scoreboard: every transferred result is compared field by field with
    // the oldest expectation.
    always @(posedge clk)
    begin
        exec_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, alu_result",
                                out_data.alu_result, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.alu_result !== want.alu_result)
                    report_mismatch("alu_result", out_data.alu_result, want.alu_result);
                if (out_data.store_data !== want.store_data)
                    report_mismatch("store_data", out_data.store_data, want.store_data);
                if (out_data.dest_reg_out !== want.dest_reg_out)
                    report_mismatch("dest_reg_out", XLEN'(out_data.dest_reg_out),
                                    XLEN'(want.dest_reg_out));
                if (out_data.link_address_out !== want.link_address_out)
                    report_mismatch("link_address_out", out_data.link_address_out,
                                    want.link_address_out);
                if (out_data.redirect !== want.redirect)
                    report_mismatch("redirect", XLEN'(out_data.redirect), XLEN'(want.redirect));
                if (out_data.next_pc !== want.next_pc)
                    report_mismatch("next_pc", out_data.next_pc, want.next_pc);
            end
        end
    end

    // Main sequence: reset, directed table, then random phases, with a register
    // write before the directed table and before each random phase.
    initial
    begin
        logic [XLEN-1:0] cfg_values[4];
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        // Reset clears pc_reset_value to zero and loads the pc with the same default.
        arch_pc      = PC_RESET_DEFAULT;

        // Rows with a typed result start from reset and step the pc by four up to
        // the register-relative jump, the first redirect; the rows after it are
        // checked against the predictor only.
        directed_tbl.push_back('{instr('0, '0, '0, 1'b0, ALU_ADD, 1'b0, BR_EQ, 1'b0, 1'b0,
            5'd0, '0), 1'b1, outcome('0, '0, 5'd0, '0, 1'b0, 32'd4)});
        // Adder wraps: all ones plus one.
        directed_tbl.push_back('{instr('1, 32'h1234_5678, 32'd1, 1'b1, ALU_ADD, 1'b0, BR_EQ,
            1'b0, 1'b0, 5'd31, '1), 1'b1, outcome('0, 32'h1234_5678, 5'd31, '1, 1'b0, 32'd8)});
        directed_tbl.push_back('{instr('0, 32'd1, '0, 1'b0, ALU_SUB, 1'b0, BR_EQ, 1'b0, 1'b0,
            5'd1, 32'd4), 1'b1, outcome('1, 32'd1, 5'd1, 32'd4, 1'b0, 32'd12)});
        // Most negative against most positive: signed and unsigned disagree.
        directed_tbl.push_back('{instr(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0, ALU_SLT, 1'b0,
            BR_EQ, 1'b0, 1'b0, 5'd2, 32'd8), 1'b1,
            outcome(32'd1, 32'h7FFF_FFFF, 5'd2, 32'd8, 1'b0, 32'd16)});
        directed_tbl.push_back('{instr(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b0, ALU_LTU, 1'b0,
            BR_EQ, 1'b0, 1'b0, 5'd3, 32'd12), 1'b1,
            outcome('0, 32'h7FFF_FFFF, 5'd3, 32'd12, 1'b0, 32'd20)});
        directed_tbl.push_back('{instr(32'hAAAA_AAAA, 32'h5555_5555, '0, 1'b0, ALU_OR, 1'b0,
            BR_EQ, 1'b0, 1'b0, 5'd4, 32'd16), 1'b1,
            outcome('1, 32'h5555_5555, 5'd4, 32'd16, 1'b0, 32'd24)});
        directed_tbl.push_back('{instr('1, '1, '0, 1'b0, ALU_XOR, 1'b0, BR_EQ, 1'b0, 1'b0,
            5'd5, 32'd20), 1'b1, outcome('0, '1, 5'd5, 32'd20, 1'b0, 32'd28)});
        directed_tbl.push_back('{instr('1, 32'h0F0F_0F0F, '0, 1'b0, ALU_AND, 1'b0, BR_EQ, 1'b0,
            1'b0, 5'd6, 32'd24), 1'b1,
            outcome(32'h0F0F_0F0F, 32'h0F0F_0F0F, 5'd6, 32'd24, 1'b0, 32'd32)});
        // Shift amount comes from the low five bits only: all ones means 31.
        directed_tbl.push_back('{instr(32'd1, '0, '1, 1'b1, ALU_SLL, 1'b0, BR_EQ, 1'b0, 1'b0,
            5'd7, 32'd28), 1'b1, outcome(32'h8000_0000, '0, 5'd7, 32'd28, 1'b0, 32'd36)});
        // An amount of 32 wraps to a shift by zero.
        directed_tbl.push_back('{instr(32'h8000_0000, '0, 32'h20, 1'b1, ALU_SRL, 1'b0, BR_EQ,
            1'b0, 1'b0, 5'd8, 32'd32), 1'b1,
            outcome(32'h8000_0000, '0, 5'd8, 32'd32, 1'b0, 32'd40)});
        // Arithmetic shift by zero must leave a negative value alone.
        directed_tbl.push_back('{instr(32'h8000_0000, '0, '0, 1'b0, ALU_SRA, 1'b0, BR_EQ, 1'b0,
            1'b0, 5'd9, 32'd36), 1'b1,
            outcome(32'h8000_0000, '0, 5'd9, 32'd36, 1'b0, 32'd44)});
        directed_tbl.push_back('{instr(32'h8000_0000, 32'h1F, '0, 1'b0, ALU_SRA, 1'b0, BR_EQ,
            1'b0, 1'b0, 5'd10, 32'd40), 1'b1,
            outcome('1, 32'h1F, 5'd10, 32'd40, 1'b0, 32'd48)});
        // Undefined opcodes produce zero.
        directed_tbl.push_back('{instr('1, '1, '0, 1'b0, ALU_UNUSED_HI, 1'b0, BR_EQ, 1'b0,
            1'b0, 5'd11, 32'd44), 1'b1, outcome('0, '1, 5'd11, 32'd44, 1'b0, 32'd52)});
        directed_tbl.push_back('{instr(32'h1234_5678, 32'd1, '0, 1'b0, ALU_UNUSED_LO, 1'b0,
            BR_EQ, 1'b0, 1'b0, 5'd12, 32'd48), 1'b1,
            outcome('0, 32'd1, 5'd12, 32'd48, 1'b0, 32'd56)});
        // Undefined branch kinds never take, even with jump_taken set.
        directed_tbl.push_back('{instr(32'd5, 32'd5, 32'd100, 1'b0, ALU_ADD, 1'b1, BR_NEVER_LO,
            1'b1, 1'b0, 5'd13, 32'd52), 1'b1,
            outcome(32'd10, 32'd5, 5'd13, 32'd52, 1'b0, 32'd60)});
        directed_tbl.push_back('{instr('0, '0, 32'd100, 1'b0, ALU_ADD, 1'b1, BR_NEVER_HI, 1'b1,
            1'b0, 5'd14, 32'd56), 1'b1, outcome('0, '0, 5'd14, 32'd56, 1'b0, 32'd64)});
        // Register-relative jump whose target wraps past the top of memory.
        directed_tbl.push_back('{instr(32'hFFFF_FFF0, '0, 32'h20, 1'b1, ALU_ADD, 1'b0, BR_EQ,
            1'b1, 1'b1, 5'd15, 32'd60), 1'b1,
            outcome(32'h10, '0, 5'd15, 32'd60, 1'b1, 32'h10)});
        // Branches: jump_taken is ignored and the compare decides.
        directed_tbl.push_back('{instr(32'd7, 32'd7, 32'd8, 1'b0, ALU_SUB, 1'b1, BR_EQ, 1'b0,
            1'b0, 5'd16, 32'd64), 1'b0, '0});
        directed_tbl.push_back('{instr(32'd7, 32'd7, 32'd8, 1'b0, ALU_XOR, 1'b1, BR_NE, 1'b1,
            1'b0, 5'd17, 32'd68), 1'b0, '0});
        directed_tbl.push_back('{instr(32'h8000_0000, 32'd1, 32'hFFFF_FFF8, 1'b0, ALU_SLT, 1'b1,
            BR_LT, 1'b0, 1'b0, 5'd18, 32'd72), 1'b0, '0});
        directed_tbl.push_back('{instr(32'h8000_0000, 32'd1, 32'hFFFF_FFF8, 1'b0, ALU_LTU, 1'b1,
            BR_GE, 1'b1, 1'b0, 5'd19, 32'd76), 1'b0, '0});
        directed_tbl.push_back('{instr(32'd1, 32'h8000_0000, 32'h40, 1'b0, ALU_OR, 1'b1, BR_LTU,
            1'b0, 1'b1, 5'd20, 32'd80), 1'b0, '0});
        // Compare against the immediate: all ones is unsigned-greater-or-equal zero.
        directed_tbl.push_back('{instr('1, 32'h55, '0, 1'b1, ALU_AND, 1'b1, BR_GEU, 1'b0, 1'b0,
            5'd21, 32'd84), 1'b0, '0});
        directed_tbl.push_back('{instr(32'd5, '0, '1, 1'b1, ALU_SRA, 1'b1, BR_LT, 1'b1, 1'b0,
            5'd22, 32'd88), 1'b0, '0});
        directed_tbl.push_back('{instr('0, '1, 32'h7FFF_FFFC, 1'b1, ALU_SLL, 1'b0, BR_EQ, 1'b1,
            1'b0, 5'd23, 32'd92), 1'b0, '0});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_pc_reset('1);
        foreach (directed_tbl[i])
            send_instr(directed_tbl[i].instr, directed_tbl[i].has_result,
                       directed_tbl[i].result);
        drain_pipeline();

        // Register values written before each random phase: zero, the sign bit, a random word, 32'h7FFF_FFFC.
        cfg_values[0] = '0;
        cfg_values[1] = 32'h8000_0000;
        cfg_values[2] = $urandom;
        cfg_values[3] = 32'h7FFF_FFFC;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_pc_reset(cfg_values[phase]);
            repeat (125)
                send_instr(random_instr(), 1'b0, '0);
            drain_pipeline();
        end

        // Give a stray extra result time to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
